FILE: hdl/lmsnt_pkg.sv
// ----------------------------------------------------------------------------
// lmsnt_pkg
// Shared types, widths, codes and saturation helpers for the two-input
// LMS neuron trainer.
// ----------------------------------------------------------------------------
package lmsnt_pkg;

  // Field widths and fixed-point formats
  localparam int DATA_WIDTH   = 16;  // Q8.8 samples, prediction, error
  localparam int WEIGHT_WIDTH = 24;  // Q8.16 weights and bias
  localparam int RATE_WIDTH   = 16;  // Q0.16 step size, unsigned
  localparam int DATA_FRAC    = 8;
  localparam int WEIGHT_FRAC  = 16;
  localparam int RATE_FRAC    = 16;

  // Gradient step g = 2*rate*error: unsigned rate, signed error, doubled
  localparam int G_WIDTH     = RATE_WIDTH + DATA_WIDTH + 2;
  // Multiplicand of the serial multiplier covers weights, rate and g
  localparam int MCAND_WIDTH = (G_WIDTH > WEIGHT_WIDTH) ? G_WIDTH : WEIGHT_WIDTH;
  localparam int PROD_WIDTH  = MCAND_WIDTH + DATA_WIDTH;
  // Prediction accumulator: two products plus the shifted bias
  localparam int ACC_WIDTH   = PROD_WIDTH + 2;
  // Weight update difference
  localparam int UPD_WIDTH   = PROD_WIDTH + 1;

  // Rounding shifts of the updates
  localparam int WSH = RATE_FRAC + DATA_FRAC + DATA_FRAC - WEIGHT_FRAC;
  localparam int BSH = RATE_FRAC + DATA_FRAC - WEIGHT_FRAC;

  // Configuration port
  localparam int CFG_INDEX_WIDTH = 2;
  localparam int CFG_DATA_WIDTH  = WEIGHT_WIDTH;

  localparam logic [CFG_INDEX_WIDTH-1:0] REG_LEARN_RATE = 2'd0;
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_INIT_W1    = 2'd1;
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_INIT_W2    = 2'd2;
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_INIT_BIAS  = 2'd3;

  localparam logic [RATE_WIDTH-1:0] RATE_RESET = 16'd16384;  // 0.25

  // Op codes
  localparam logic [1:0] OP_PREDICT = 2'd0;
  localparam logic [1:0] OP_TRAIN   = 2'd1;
  localparam logic [1:0] OP_RELOAD  = 2'd2;

  // Saturation bounds, held at the width of the value being clipped
  localparam logic signed [ACC_WIDTH-1:0] DATA_HI =
    {{(ACC_WIDTH-DATA_WIDTH+1){1'b0}}, {(DATA_WIDTH-1){1'b1}}};
  localparam logic signed [ACC_WIDTH-1:0] DATA_LO =
    {{(ACC_WIDTH-DATA_WIDTH+1){1'b1}}, {(DATA_WIDTH-1){1'b0}}};
  localparam logic signed [UPD_WIDTH-1:0] WGT_HI =
    {{(UPD_WIDTH-WEIGHT_WIDTH+1){1'b0}}, {(WEIGHT_WIDTH-1){1'b1}}};
  localparam logic signed [UPD_WIDTH-1:0] WGT_LO =
    {{(UPD_WIDTH-WEIGHT_WIDTH+1){1'b1}}, {(WEIGHT_WIDTH-1){1'b0}}};

  // Payloads
  typedef struct packed {
    logic [1:0]                   op;
    logic signed [DATA_WIDTH-1:0] first_input;
    logic signed [DATA_WIDTH-1:0] second_input;
    logic signed [DATA_WIDTH-1:0] target_value;
  } sample_t;

  typedef struct packed {
    logic signed [DATA_WIDTH-1:0]   prediction;
    logic signed [DATA_WIDTH-1:0]   error_value;
    logic signed [WEIGHT_WIDTH-1:0] weight_one_now;
    logic signed [WEIGHT_WIDTH-1:0] weight_two_now;
    logic signed [WEIGHT_WIDTH-1:0] bias_now;
    logic                           saturated_flag;
  } result_t;

  // Serial multiplier status
  typedef struct packed {
    logic busy;
    logic done;
  } mul_stat_t;

  // Sequencer states
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MUL_W1,
    ST_MUL_W2,
    ST_ROUND,
    ST_ERROR,
    ST_MUL_G,
    ST_MUL_D1,
    ST_UPD_W1,
    ST_MUL_D2,
    ST_UPD_W2,
    ST_RND_B,
    ST_UPD_B,
    ST_EMIT
  } state_t;

  // Clipped value plus clip indication
  typedef struct packed {
    logic signed [DATA_WIDTH-1:0] value;
    logic                         clipped;
  } data_clip_t;

  typedef struct packed {
    logic signed [WEIGHT_WIDTH-1:0] value;
    logic                           clipped;
  } weight_clip_t;

  function automatic data_clip_t clip_data(input logic signed [ACC_WIDTH-1:0] v);
    data_clip_t r;
    if (v > DATA_HI) begin
      r.value   = DATA_HI[DATA_WIDTH-1:0];
      r.clipped = 1'b1;
    end else if (v < DATA_LO) begin
      r.value   = DATA_LO[DATA_WIDTH-1:0];
      r.clipped = 1'b1;
    end else begin
      r.value   = v[DATA_WIDTH-1:0];
      r.clipped = 1'b0;
    end
    return r;
  endfunction

  function automatic weight_clip_t clip_weight(input logic signed [UPD_WIDTH-1:0] v);
    weight_clip_t r;
    if (v > WGT_HI) begin
      r.value   = WGT_HI[WEIGHT_WIDTH-1:0];
      r.clipped = 1'b1;
    end else if (v < WGT_LO) begin
      r.value   = WGT_LO[WEIGHT_WIDTH-1:0];
      r.clipped = 1'b1;
    end else begin
      r.value   = v[WEIGHT_WIDTH-1:0];
      r.clipped = 1'b0;
    end
    return r;
  endfunction

endpackage

FILE: hdl/lms_two_input_neuron_trainer.sv
// ----------------------------------------------------------------------------
// lms_two_input_neuron_trainer
// Two-input ADALINE neuron with LMS training in fixed point. All products go
// through one shared bit-serial multiplier under a small sequencer.
//
//   channel  | signals                                   | role
//   ---------+-------------------------------------------+-------------------
//   sample   | sample_valid, sample_ready, sample        | op, x1, x2, target
//   result   | result_valid, result_ready, result        | pred, err, weights
//   config   | cfg_write, cfg_index, cfg_data            | rate, init values
//
// Each product runs in the shared multiplier as a load, a serial step per
// multiplier bit and a done; predict items need two, train items five.
// Reset is synchronous; weights and bias come up at zero, rate at 0.25.
// A new item is taken while a finished result still waits; the sequencer
// holds in its last step until the result register is free.
// ----------------------------------------------------------------------------
module lms_two_input_neuron_trainer
  import lmsnt_pkg::*;
(
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       sample_valid,
  output logic                       sample_ready,
  input  sample_t                    sample,
  output logic                       result_valid,
  input  logic                       result_ready,
  output result_t                    result,
  input  logic                       cfg_write,
  input  logic [CFG_INDEX_WIDTH-1:0] cfg_index,
  input  logic [CFG_DATA_WIDTH-1:0]  cfg_data
);

  localparam logic signed [ACC_WIDTH-1:0] PRED_HALF =
    {{(ACC_WIDTH-WEIGHT_FRAC){1'b0}}, 1'b1, {(WEIGHT_FRAC-1){1'b0}}};
  localparam logic signed [PROD_WIDTH-1:0] DELTA_HALF =
    {{(PROD_WIDTH-WSH){1'b0}}, 1'b1, {(WSH-1){1'b0}}};
  localparam logic signed [PROD_WIDTH-1:0] BIAS_HALF =
    {{(PROD_WIDTH-BSH){1'b0}}, 1'b1, {(BSH-1){1'b0}}};

  // Sequencer
  state_t state;
  state_t state_next;

  // Configuration registers
  logic [RATE_WIDTH-1:0]          learn_rate;
  logic signed [WEIGHT_WIDTH-1:0] init_weight_one;
  logic signed [WEIGHT_WIDTH-1:0] init_weight_two;
  logic signed [WEIGHT_WIDTH-1:0] init_bias;

  // Neuron state
  logic signed [WEIGHT_WIDTH-1:0] weight_one;
  logic signed [WEIGHT_WIDTH-1:0] weight_two;
  logic signed [WEIGHT_WIDTH-1:0] bias_value;

  // Item registers
  logic [1:0]                   op_q;
  logic signed [DATA_WIDTH-1:0] x1_q;
  logic signed [DATA_WIDTH-1:0] x2_q;
  logic signed [DATA_WIDTH-1:0] tgt_q;
  logic signed [ACC_WIDTH-1:0]  acc;
  logic signed [DATA_WIDTH-1:0] pred_q;
  logic signed [DATA_WIDTH-1:0] err_q;
  logic signed [G_WIDTH-1:0]    g_q;
  logic signed [PROD_WIDTH-1:0] d_q;
  logic                         flag_q;

  // Multiplier hookup
  logic                          mul_start;
  logic signed [MCAND_WIDTH-1:0] mul_mcand;
  logic signed [DATA_WIDTH-1:0]  mul_mplr;
  logic signed [PROD_WIDTH-1:0]  mul_product;
  mul_stat_t                     mul_stat;
  logic                          mul_state;

  // Control strobes
  logic sample_accept;
  logic load_result;

  // Datapath intermediates
  logic signed [ACC_WIDTH-1:0]    bias_shifted;
  logic signed [ACC_WIDTH-1:0]    prod_ext;
  logic signed [ACC_WIDTH-1:0]    acc_round;
  logic signed [ACC_WIDTH-1:0]    pred_wide;
  data_clip_t                     pred_clip;
  logic [DATA_WIDTH:0]            err_diff;
  logic signed [ACC_WIDTH-1:0]    err_wide;
  data_clip_t                     err_clip;
  logic signed [PROD_WIDTH-1:0]   prod_round;
  logic signed [PROD_WIDTH-1:0]   delta_prod;
  logic signed [PROD_WIDTH-1:0]   g_ext;
  logic signed [PROD_WIDTH-1:0]   g_round;
  logic signed [PROD_WIDTH-1:0]   delta_bias;
  logic signed [WEIGHT_WIDTH-1:0] w_sel;
  logic signed [UPD_WIDTH-1:0]    w_sel_ext;
  logic signed [UPD_WIDTH-1:0]    d_ext;
  logic signed [UPD_WIDTH-1:0]    upd_diff;
  weight_clip_t                   upd_clip;

  assign sample_accept = sample_valid && sample_ready;

  // Shared serial multiplier
  lmsnt_serial_mul u_mul (
    .clk     (clk),
    .rst     (rst),
    .start   (mul_start),
    .mcand   (mul_mcand),
    .mplr    (mul_mplr),
    .product (mul_product),
    .stat    (mul_stat)
  );

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (sample_valid) begin
          state_next = (sample.op == OP_RELOAD) ? ST_EMIT : ST_MUL_W1;
        end
      end
      ST_MUL_W1: if (mul_stat.done) state_next = ST_MUL_W2;
      ST_MUL_W2: if (mul_stat.done) state_next = ST_ROUND;
      ST_ROUND:  state_next = ST_ERROR;
      ST_ERROR:  state_next = (op_q == OP_TRAIN) ? ST_MUL_G : ST_EMIT;
      ST_MUL_G:  if (mul_stat.done) state_next = ST_MUL_D1;
      ST_MUL_D1: if (mul_stat.done) state_next = ST_UPD_W1;
      ST_UPD_W1: state_next = ST_MUL_D2;
      ST_MUL_D2: if (mul_stat.done) state_next = ST_UPD_W2;
      ST_UPD_W2: state_next = ST_RND_B;
      ST_RND_B:  state_next = ST_UPD_B;
      ST_UPD_B:  state_next = ST_EMIT;
      ST_EMIT: begin
        if (!result_valid || result_ready) begin
          state_next = ST_IDLE;
        end
      end
      default:   state_next = ST_IDLE;
    endcase
  end

  // Sequencer outputs: handshake, multiplier operands
  always_comb begin
    sample_ready = 1'b0;
    load_result  = 1'b0;
    mul_state    = 1'b0;
    mul_mcand    = '0;
    mul_mplr     = '0;
    case (state)
      ST_IDLE: sample_ready = 1'b1;
      ST_MUL_W1: begin
        mul_state = 1'b1;
        mul_mcand = $signed({{(MCAND_WIDTH-WEIGHT_WIDTH){weight_one[WEIGHT_WIDTH-1]}},
                             weight_one});
        mul_mplr  = x1_q;
      end
      ST_MUL_W2: begin
        mul_state = 1'b1;
        mul_mcand = $signed({{(MCAND_WIDTH-WEIGHT_WIDTH){weight_two[WEIGHT_WIDTH-1]}},
                             weight_two});
        mul_mplr  = x2_q;
      end
      ST_MUL_G: begin
        mul_state = 1'b1;
        mul_mcand = $signed({{(MCAND_WIDTH-RATE_WIDTH){1'b0}}, learn_rate});
        mul_mplr  = err_q;
      end
      ST_MUL_D1: begin
        mul_state = 1'b1;
        mul_mcand = MCAND_WIDTH'(g_q);
        mul_mplr  = x1_q;
      end
      ST_MUL_D2: begin
        mul_state = 1'b1;
        mul_mcand = MCAND_WIDTH'(g_q);
        mul_mplr  = x2_q;
      end
      ST_EMIT: load_result = !result_valid || result_ready;
      default: ;
    endcase
    mul_start = mul_state && !mul_stat.busy && !mul_stat.done;
  end

  // Arithmetic between steps
  always_comb begin
    bias_shifted = $signed({{(ACC_WIDTH-WEIGHT_WIDTH-DATA_FRAC){bias_value[WEIGHT_WIDTH-1]}},
                            bias_value, {DATA_FRAC{1'b0}}});
    prod_ext     = $signed({{(ACC_WIDTH-PROD_WIDTH){mul_product[PROD_WIDTH-1]}},
                            mul_product});
    // prediction: round to Q8.8, ties up, then clip
    acc_round    = acc + PRED_HALF;
    pred_wide    = acc_round >>> WEIGHT_FRAC;
    pred_clip    = clip_data(pred_wide);
    // error: prediction minus target
    err_diff     = {pred_q[DATA_WIDTH-1], pred_q} - {tgt_q[DATA_WIDTH-1], tgt_q};
    err_wide     = $signed({{(ACC_WIDTH-DATA_WIDTH-1){err_diff[DATA_WIDTH]}}, err_diff});
    err_clip     = clip_data(err_wide);
    // weight deltas: g*x rounded to Q8.16
    prod_round   = mul_product + DELTA_HALF;
    delta_prod   = prod_round >>> WSH;
    // bias delta: g rounded to Q8.16
    g_ext        = $signed({{(PROD_WIDTH-G_WIDTH){g_q[G_WIDTH-1]}}, g_q});
    g_round      = g_ext + BIAS_HALF;
    delta_bias   = g_round >>> BSH;
    // one shared update subtractor
    case (state)
      ST_UPD_W1: w_sel = weight_one;
      ST_UPD_W2: w_sel = weight_two;
      default:   w_sel = bias_value;
    endcase
    w_sel_ext = $signed({{(UPD_WIDTH-WEIGHT_WIDTH){w_sel[WEIGHT_WIDTH-1]}}, w_sel});
    d_ext     = $signed({d_q[PROD_WIDTH-1], d_q});
    upd_diff  = w_sel_ext - d_ext;
    upd_clip  = clip_weight(upd_diff);
  end

  // Control state, configuration and weights
  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= ST_IDLE;
      result_valid    <= 1'b0;
      learn_rate      <= RATE_RESET;
      init_weight_one <= '0;
      init_weight_two <= '0;
      init_bias       <= '0;
      weight_one      <= '0;
      weight_two      <= '0;
      bias_value      <= '0;
    end else begin
      state <= state_next;

      if (load_result) begin
        result_valid <= 1'b1;
      end else if (result_ready) begin
        result_valid <= 1'b0;
      end

      if (cfg_write) begin
        case (cfg_index)
          REG_LEARN_RATE: learn_rate      <= cfg_data[RATE_WIDTH-1:0];
          REG_INIT_W1:    init_weight_one <= cfg_data[WEIGHT_WIDTH-1:0];
          REG_INIT_W2:    init_weight_two <= cfg_data[WEIGHT_WIDTH-1:0];
          REG_INIT_BIAS:  init_bias       <= cfg_data[WEIGHT_WIDTH-1:0];
          default: ;
        endcase
      end

      if (sample_accept && sample.op == OP_RELOAD) begin
        weight_one <= init_weight_one;
        weight_two <= init_weight_two;
        bias_value <= init_bias;
      end
      if (state == ST_UPD_W1) weight_one <= upd_clip.value;
      if (state == ST_UPD_W2) weight_two <= upd_clip.value;
      if (state == ST_UPD_B)  bias_value <= upd_clip.value;
    end
  end

  // Item datapath
  always_ff @(posedge clk) begin
    if (sample_accept) begin
      op_q   <= sample.op;
      x1_q   <= sample.first_input;
      x2_q   <= sample.second_input;
      tgt_q  <= sample.target_value;
      acc    <= bias_shifted;
      pred_q <= '0;
      err_q  <= '0;
      flag_q <= 1'b0;
    end
    case (state)
      ST_MUL_W1, ST_MUL_W2: begin
        if (mul_stat.done) acc <= acc + prod_ext;
      end
      ST_ROUND: begin
        pred_q <= pred_clip.value;
        flag_q <= flag_q | pred_clip.clipped;
      end
      ST_ERROR: begin
        err_q  <= err_clip.value;
        flag_q <= flag_q | err_clip.clipped;
      end
      ST_MUL_G: begin
        if (mul_stat.done) g_q <= {mul_product[G_WIDTH-2:0], 1'b0};
      end
      ST_MUL_D1, ST_MUL_D2: begin
        if (mul_stat.done) d_q <= delta_prod;
      end
      ST_RND_B: d_q <= delta_bias;
      ST_UPD_W1, ST_UPD_W2, ST_UPD_B: flag_q <= flag_q | upd_clip.clipped;
      default: ;
    endcase
  end

  // Result register
  always_ff @(posedge clk) begin
    if (load_result) begin
      result.prediction     <= pred_q;
      result.error_value    <= err_q;
      result.weight_one_now <= weight_one;
      result.weight_two_now <= weight_two;
      result.bias_now       <= bias_value;
      result.saturated_flag <= flag_q;
    end
  end

`ifndef SYNTH
  // The multiplier is only started when idle and its last product is consumed
  a_mul_start_idle: assert property (@(posedge clk) disable iff (rst)
    mul_start |-> (!mul_stat.busy && !mul_stat.done))
    else $error("serial multiplier started while busy");

  // A finished product only appears in a multiply step
  a_done_in_mul_step: assert property (@(posedge clk) disable iff (rst)
    mul_stat.done |-> (state == ST_MUL_W1 || state == ST_MUL_W2 || state == ST_MUL_G ||
                       state == ST_MUL_D1 || state == ST_MUL_D2))
    else $error("multiplier done outside a multiply step");

  // First weight only moves on its update step or a reload
  a_weight_one_hold: assert property (@(posedge clk) disable iff (rst)
    (state != ST_UPD_W1 && state != ST_IDLE) |=> $stable(weight_one))
    else $error("weight_one changed outside its update");
`endif

endmodule

FILE: hdl/lmsnt_serial_mul.sv
// ----------------------------------------------------------------------------
// lmsnt_serial_mul
// Bit-serial signed shift-and-add multiplier. The multiplier operand shifts
// out one bit per cycle, LSB first; the top bit carries negative weight.
// ----------------------------------------------------------------------------
module lmsnt_serial_mul
  import lmsnt_pkg::*;
(
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  input  logic signed [MCAND_WIDTH-1:0]  mcand,
  input  logic signed [DATA_WIDTH-1:0]   mplr,
  output logic signed [PROD_WIDTH-1:0]   product,
  output mul_stat_t                      stat
);

  localparam int CNT_WIDTH = $clog2(DATA_WIDTH);
  localparam logic [CNT_WIDTH-1:0] CNT_LAST = CNT_WIDTH'(DATA_WIDTH - 1);

  logic                         busy;
  logic                         done;
  logic [CNT_WIDTH-1:0]         cnt;
  logic signed [PROD_WIDTH-1:0] mcand_sh;
  logic [DATA_WIDTH-1:0]        mplr_sh;
  logic signed [PROD_WIDTH-1:0] prod;
  logic signed [PROD_WIDTH-1:0] addend;
  logic signed [PROD_WIDTH-1:0] prod_next;
  logic                         last;

  assign last = (cnt == CNT_LAST);

  // One partial product per cycle; sign bit of multiplier is subtracted
  always_comb begin
    addend    = mplr_sh[0] ? mcand_sh : '0;
    prod_next = last ? (prod - addend) : (prod + addend);
  end

  // Control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start && !busy) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (last) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Shift registers and accumulator
  always_ff @(posedge clk) begin
    if (start && !busy) begin
      mcand_sh <= $signed({{(PROD_WIDTH-MCAND_WIDTH){mcand[MCAND_WIDTH-1]}}, mcand});
      mplr_sh  <= mplr;
      prod     <= '0;
    end else if (busy) begin
      mcand_sh <= mcand_sh <<< 1;
      mplr_sh  <= mplr_sh >> 1;
      prod     <= prod_next;
    end
  end

  assign product   = prod;
  assign stat.busy = busy;
  assign stat.done = done;

endmodule

FILE: bench/lms_two_input_neuron_trainer_test.sv
// ----------------------------------------------------------------------------
// lms_two_input_neuron_trainer_test
// Self-checking bench for the two-input LMS neuron trainer. A queue of sample
// items feeds a clocked driver and a clocked monitor checks each result item
// against a bit-exact fixed-point model of the neuron. The run opens with
// directed extremes and saturation cases, then goes through several
// configuration phases of random items. Most of them follow a hidden linear
// target, most of those as training items; the rest are noise. Both sides
// idle at random, and one phase holds the result side off for a long stretch.
// ----------------------------------------------------------------------------
module lms_two_input_neuron_trainer_test;
  import lmsnt_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [1:0] OP_SPARE = 2'd3;   // unused code, acts as predict
  localparam int     IDLE_PCT    = 9;
  localparam int     PHASES      = 8;
  localparam int     PHASE_ITEMS = 200;
  localparam int     HOLD_CYCLES = 600;
  localparam int     TAIL_CYCLES = 200;
  localparam longint W_MAX       = 64'sd8388607;
  localparam longint W_MIN       = -64'sd8388608;

  logic clk = 1'b0;
  logic rst;

  logic                       sample_valid = 1'b0;
  logic                       sample_ready;
  sample_t                    sample_item  = '0;
  logic                       result_valid;
  logic                       result_ready = 1'b0;
  result_t                    result_item;
  logic                       cfg_write;
  logic [CFG_INDEX_WIDTH-1:0] cfg_index;
  logic [CFG_DATA_WIDTH-1:0]  cfg_data;

  sample_t pending_samples[$];
  result_t expected_results[$];

  // Neuron model: configuration copy and learned parameters
  longint step_rate, init_one, init_two, init_bias_val;
  longint w_one, w_two, w_bias;

  // Hidden line that the learnable items follow
  longint teach_a, teach_b, teach_c;

  bit steady = 1'b0;
  int sink_hold_left = 0;

  int error_count = 0;
  int n_train = 0, n_predict = 0, n_reload = 0, n_spare = 0;
  int n_results = 0, n_saturated = 0, n_cfg_writes = 0;

  lms_two_input_neuron_trainer dut (
    .clk          (clk),
    .rst          (rst),
    .sample_valid (sample_valid),
    .sample_ready (sample_ready),
    .sample       (sample_item),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result_item),
    .cfg_write    (cfg_write),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // --------------------------------------------------------------------------
  // Fixed-point helpers
  // --------------------------------------------------------------------------
  function automatic longint clamp(input longint v, input int w, inout logic hit);
    longint hi, lo;
    hi = (longint'(1) <<< (w - 1)) - 1;
    lo = -hi - 1;
    if (v > hi) begin
      hit = 1'b1;
      return hi;
    end
    if (v < lo) begin
      hit = 1'b1;
      return lo;
    end
    return v;
  endfunction

  // Round to nearest, ties toward plus infinity
  function automatic longint round_half_up(input longint v, input int s);
    return (v + (longint'(1) <<< (s - 1))) >>> s;
  endfunction

  // One sample item through the neuron; updates the learned parameters
  function automatic result_t neuron_step(input sample_t s);
    result_t r;
    longint  x1, x2, tgt, acc, pred, err, g;
    logic    hit;
    x1   = longint'($signed(s.first_input));
    x2   = longint'($signed(s.second_input));
    tgt  = longint'($signed(s.target_value));
    pred = 0;
    err  = 0;
    hit  = 1'b0;
    if (s.op == OP_RELOAD) begin
      w_one  = init_one;
      w_two  = init_two;
      w_bias = init_bias_val;
    end else begin
      acc  = x1 * w_one + x2 * w_two + (w_bias <<< DATA_FRAC);
      pred = clamp(round_half_up(acc, WEIGHT_FRAC), DATA_WIDTH, hit);
      err  = clamp(pred - tgt, DATA_WIDTH, hit);
      // all three updates come from the same error
      if (s.op == OP_TRAIN) begin
        g      = step_rate * err * 2;
        w_one  = clamp(w_one - round_half_up(g * x1, WSH), WEIGHT_WIDTH, hit);
        w_two  = clamp(w_two - round_half_up(g * x2, WSH), WEIGHT_WIDTH, hit);
        w_bias = clamp(w_bias - round_half_up(g, BSH), WEIGHT_WIDTH, hit);
      end
    end
    r.prediction     = pred[DATA_WIDTH-1:0];
    r.error_value    = err[DATA_WIDTH-1:0];
    r.weight_one_now = w_one[WEIGHT_WIDTH-1:0];
    r.weight_two_now = w_two[WEIGHT_WIDTH-1:0];
    r.bias_now       = w_bias[WEIGHT_WIDTH-1:0];
    r.saturated_flag = hit;
    return r;
  endfunction

  task automatic note_mismatch(input string what, input longint got, input longint want);
    $display("mismatch at %0t: %s got %0d expected %0d", $realtime, what, got, want);
    error_count++;
  endtask

  // --------------------------------------------------------------------------
  // Driver: offers queued sample items, predicts each one as it is accepted
  // --------------------------------------------------------------------------
  always @(posedge clk) begin : source
    logic offered;
    if (rst) begin
      sample_valid <= 1'b0;
    end else begin
      offered = sample_valid;
      if (sample_valid && sample_ready) begin
        expected_results.push_back(neuron_step(sample_item));
        case (sample_item.op)
          OP_TRAIN:   n_train++;
          OP_PREDICT: n_predict++;
          OP_RELOAD:  n_reload++;
          default:    n_spare++;
        endcase
        offered = 1'b0;
      end
      if (!offered) begin
        if (pending_samples.size() != 0 && (steady || $urandom_range(0, 99) >= IDLE_PCT)) begin
          sample_item  <= pending_samples.pop_front();
          sample_valid <= 1'b1;
        end else begin
          sample_valid <= 1'b0;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Monitor: checks each result item against the oldest prediction
  // --------------------------------------------------------------------------
  always @(posedge clk) begin : sink
    result_t want;
    if (rst) begin
      result_ready <= 1'b0;
    end else begin
      if (result_valid && result_ready) begin
        n_results++;
        if (result_item.saturated_flag) n_saturated++;
        if (expected_results.size() == 0) begin
          note_mismatch("result with nothing pending", 0, 0);
        end else begin
          want = expected_results.pop_front();
          if (result_item.prediction !== want.prediction)
            note_mismatch("prediction", result_item.prediction, want.prediction);
          if (result_item.error_value !== want.error_value)
            note_mismatch("error_value", result_item.error_value, want.error_value);
          if (result_item.weight_one_now !== want.weight_one_now)
            note_mismatch("weight_one_now", result_item.weight_one_now,
                          want.weight_one_now);
          if (result_item.weight_two_now !== want.weight_two_now)
            note_mismatch("weight_two_now", result_item.weight_two_now,
                          want.weight_two_now);
          if (result_item.bias_now !== want.bias_now)
            note_mismatch("bias_now", result_item.bias_now, want.bias_now);
          if (result_item.saturated_flag !== want.saturated_flag)
            note_mismatch("saturated_flag", result_item.saturated_flag,
                          want.saturated_flag);
        end
      end
      // long hold-off counts down here; otherwise random back-pressure
      if (sink_hold_left > 0) begin
        sink_hold_left--;
        result_ready <= 1'b0;
      end else begin
        result_ready <= steady || ($urandom_range(0, 99) >= IDLE_PCT);
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------
  task automatic write_reg(input logic [CFG_INDEX_WIDTH-1:0] idx, input longint value);
    @(posedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value[CFG_DATA_WIDTH-1:0];
    case (idx)
      REG_LEARN_RATE: step_rate     = longint'(value[RATE_WIDTH-1:0]);
      REG_INIT_W1:    init_one      = longint'($signed(value[WEIGHT_WIDTH-1:0]));
      REG_INIT_W2:    init_two      = longint'($signed(value[WEIGHT_WIDTH-1:0]));
      default:        init_bias_val = longint'($signed(value[WEIGHT_WIDTH-1:0]));
    endcase
    n_cfg_writes++;
    @(posedge clk);
    cfg_write <= 1'b0;
  endtask

  task automatic set_config(input longint rate, input longint w1, input longint w2,
                            input longint b);
    write_reg(REG_LEARN_RATE, rate);
    write_reg(REG_INIT_W1, w1);
    write_reg(REG_INIT_W2, w2);
    write_reg(REG_INIT_BIAS, b);
  endtask

  task automatic queue_item(input logic [1:0] op, input longint x1, input longint x2,
                            input longint tgt);
    sample_t s;
    s.op           = op;
    s.first_input  = x1[DATA_WIDTH-1:0];
    s.second_input = x2[DATA_WIDTH-1:0];
    s.target_value = tgt[DATA_WIDTH-1:0];
    pending_samples.push_back(s);
  endtask

  // Sender stops until the block has returned every pending result
  task automatic wait_drained();
    do @(negedge clk);
    while (pending_samples.size() != 0 || sample_valid || expected_results.size() != 0);
  endtask

  function automatic longint wild_value();
    case ($urandom_range(0, 7))
      0:       return -64'sd32768;
      1:       return 64'sd32767;
      2:       return 0;
      3:       return -1;
      default: return longint'($urandom_range(0, 65535)) - 32768;
    endcase
  endfunction

  // Mostly items on the hidden line, most of them training, with some noise items
  task automatic queue_random_item();
    longint     x1, x2, tgt;
    logic       dummy;
    logic [1:0] op;
    int         pick;
    dummy = 1'b0;
    if ($urandom_range(0, 99) < 75) begin
      x1   = longint'($urandom_range(0, 512)) - 256;
      x2   = longint'($urandom_range(0, 512)) - 256;
      tgt  = ((teach_a * x1 + teach_b * x2) >>> DATA_FRAC) + teach_c
             + longint'($urandom_range(0, 8)) - 4;
      tgt  = clamp(tgt, DATA_WIDTH, dummy);
      pick = $urandom_range(0, 99);
      if (pick < 70)      op = OP_TRAIN;
      else if (pick < 88) op = OP_PREDICT;
      else if (pick < 95) op = OP_SPARE;
      else                op = OP_RELOAD;
      queue_item(op, x1, x2, tgt);
    end else begin
      op = 2'($urandom_range(0, 3));
      queue_item(op, wild_value(), wild_value(), wild_value());
    end
  endtask

  // --------------------------------------------------------------------------
  // Reset, directed items, random phases, end of run
  // --------------------------------------------------------------------------
  initial begin : stimulus
    longint rate, w1, w2, b;
    rst       = 1'b1;
    cfg_write = 1'b0;
    cfg_index = REG_LEARN_RATE;
    cfg_data  = '0;
    step_rate     = longint'(RATE_RESET);
    init_one      = 0;
    init_two      = 0;
    init_bias_val = 0;
    w_one  = 0;
    w_two  = 0;
    w_bias = 0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Reset settings: zero weights, extremes of the fields, error clipping
    queue_item(OP_PREDICT, 0, 0, 0);
    queue_item(OP_PREDICT, 32767, -32768, 32767);
    queue_item(OP_TRAIN, 256, -256, 256);
    queue_item(OP_TRAIN, 32767, -32768, -32768);
    queue_item(OP_SPARE, 100, 200, -300);
    queue_item(OP_TRAIN, -1, 1, 32767);
    queue_item(OP_PREDICT, -32768, -32768, 0);
    queue_item(OP_RELOAD, 1234, -5678, 999);
    queue_item(OP_PREDICT, 512, 512, 0);
    wait_drained();

    // Extreme registers; weights keep their values until a reload
    set_config(65535, W_MAX, W_MIN, W_MAX);
    @(negedge clk);
    queue_item(OP_PREDICT, 32767, -32768, 0);
    queue_item(OP_RELOAD, -32768, 32767, -32768);
    queue_item(OP_PREDICT, 32767, -32768, 0);
    queue_item(OP_PREDICT, -32768, 32767, 0);
    queue_item(OP_TRAIN, 32767, -32768, -32768);
    queue_item(OP_TRAIN, 32767, -32768, -32768);
    queue_item(OP_SPARE, -32768, 32767, 32767);
    queue_item(OP_TRAIN, 0, 0, 32767);
    queue_item(OP_TRAIN, 0, 0, -32768);
    queue_item(OP_PREDICT, 0, 0, 0);
    queue_item(OP_RELOAD, 0, 0, 0);
    queue_item(OP_TRAIN, 1, -1, 0);
    queue_item(OP_PREDICT, 32767, 32767, 32767);
    wait_drained();

    // Random phases, each under its own setting
    for (int p = 0; p < PHASES; p++) begin
      case (p)
        0: begin rate = RATE_RESET; w1 = 0; w2 = 0; b = 0; end
        1: begin rate = 0; w1 = $urandom; w2 = $urandom; b = $urandom; end
        2: begin rate = 65535; w1 = W_MAX; w2 = W_MIN; b = W_MAX; end
        3: begin rate = 1; w1 = $urandom; w2 = $urandom; b = $urandom; end
        4: begin rate = $urandom_range(0, 65535); w1 = 0; w2 = 0; b = 0; end
        5: begin rate = 4096; w1 = $urandom; w2 = $urandom; b = $urandom; end
        6: begin rate = 65535; w1 = W_MIN; w2 = W_MAX; b = W_MIN; end
        default: begin
          rate = $urandom_range(0, 2048);
          w1 = longint'($urandom_range(0, 131072)) - 65536;
          w2 = longint'($urandom_range(0, 131072)) - 65536;
          b  = longint'($urandom_range(0, 131072)) - 65536;
        end
      endcase
      set_config(rate, w1, w2, b);
      @(negedge clk);
      teach_a = longint'($urandom_range(0, 1024)) - 512;
      teach_b = longint'($urandom_range(0, 1024)) - 512;
      teach_c = longint'($urandom_range(0, 1024)) - 512;
      steady  = (p == 4);
      if (p == 5) sink_hold_left = HOLD_CYCLES;
      queue_item(OP_RELOAD, 0, 0, 0);
      repeat (PHASE_ITEMS) queue_random_item();
      wait_drained();
      steady = 1'b0;
    end

    // Nothing should come out after the last expected result
    repeat (TAIL_CYCLES) @(negedge clk);

    $display("sent %0d items: %0d train, %0d predict, %0d reload, %0d unused op",
             n_train + n_predict + n_reload + n_spare, n_train, n_predict, n_reload,
             n_spare);
    $display("checked %0d results (%0d saturated) over %0d register writes, %0d mismatches",
             n_results, n_saturated, n_cfg_writes, error_count);
    if (error_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  // Run limit, far above the slowest correct run
  initial begin : watchdog
    #8_000_000;
    $display("FAIL");
    $finish;
  end

endmodule

FILE: files.f
hdl/lmsnt_pkg.sv
hdl/lmsnt_serial_mul.sv
hdl/lms_two_input_neuron_trainer.sv
bench/lms_two_input_neuron_trainer_test.sv
